>>> rtl/iaid_pkg.sv
package iaid_pkg;

    // default number of stored words
    localparam int unsigned IAID_DEPTH = 16;

    // request codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // request word
    typedef struct packed {
        logic [2:0]         op;
        logic [4:0]         position;
        logic signed [31:0] data_in;
    } iaid_req_t;

    // result word
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [4:0]         element_count;
        logic [1:0]         status;
    } iaid_rsp_t;

endpackage

>>> rtl/indexed_array_insert_delete.sv
// Ordered array of up to DEPTH signed 32-bit words with indexed access.
// Request channel s_valid/s_ready/s_payload: op (append, read, write,
// delete, insert), position and data_in. Result channel
// m_valid/m_ready/m_payload: one word per request with read_data (zero
// unless a read succeeds), element_count after the request and status
// (ok, full, index out of range). A failed request changes nothing.
// Requests are processed one at a time; s_ready is high only when the
// sequencer is idle. After acceptance, append, write and failed or
// unknown requests go straight to the result; a read first waits for
// the registered store read; delete pulls each later element down one
// place; insert moves each element from the position up one place,
// then writes the new word. Each tail element moved takes a read state
// and a write state on the word store, which has a read port and a
// separate write port. The result sits in an output register, so
// the next request is taken while it waits; if the receiver stalls, a
// following result holds in the sequencer until the register frees up.
// Synchronous reset empties the array (count zero) and drops any result.
module indexed_array_insert_delete
    import iaid_pkg::*;
#(
    parameter int unsigned DEPTH = IAID_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  iaid_req_t s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output iaid_rsp_t m_payload
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_SHRD = 6'b000100,
        S_SHWR = 6'b001000,
        S_PUT  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               del_reg, del_next;
    logic signed [31:0] data_reg, data_next;
    logic signed [31:0] rd_res_reg, rd_res_next;
    logic [1:0]         status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    iaid_rsp_t          m_payload_reg, m_payload_next;

    // word store
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic signed [31:0] mem_wd;

    // request decode at acceptance
    logic [PW-1:0] in_pos_w;
    logic [PW-1:0] cnt_w;
    logic [PW-1:0] idx_w;
    logic          full;
    logic          pos_lt;
    logic          pos_le;
    logic          del_more_in;
    logic          del_more;
    logic          ins_more;
    logic          out_free;

    assign in_pos_w    = PW'(s_payload.position);
    assign cnt_w       = PW'(count_reg);
    assign idx_w       = PW'(idx_reg);
    assign full        = (count_reg == CW'(DEPTH));
    assign pos_lt      = (in_pos_w < cnt_w);
    assign pos_le      = (in_pos_w <= cnt_w);
    // delete: another element to pull down after the one at idx
    assign del_more_in = (({1'b0, in_pos_w} + 1'b1) < {1'b0, cnt_w});
    assign del_more    = (({1'b0, idx_w} + 2'd2) < {1'b0, cnt_w});
    // insert: another element to push up below idx
    assign ins_more    = ((idx_w - 1'b1) > pos_reg);
    assign out_free    = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // read address: requested position when idle, shift source otherwise
    always_comb begin
        if (state_reg == S_IDLE) begin
            mem_ra = in_pos_w[AW-1:0];
        end else if (del_reg) begin
            mem_ra = AW'(idx_w + 1'b1);
        end else begin
            mem_ra = AW'(idx_w - 1'b1);
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        del_next       = del_reg;
        data_next      = data_reg;
        rd_res_next    = rd_res_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mem_we         = 1'b0;
        mem_wa         = in_pos_w[AW-1:0];
        mem_wd         = s_payload.data_in;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pos_next    = in_pos_w;
                    data_next   = s_payload.data_in;
                    rd_res_next = '0;
                    status_next = ST_OK;
                    idx_next    = CW'(in_pos_w);
                    del_next    = 1'b0;
                    state_next  = S_DONE;
                    case (s_payload.op)
                        OP_APPEND: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wa     = cnt_w[AW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_lt) begin
                                state_next = S_READ;
                            end else begin
                                status_next = ST_RANGE;
                            end
                        end
                        OP_WRITE: begin
                            if (pos_lt) begin
                                mem_we = 1'b1;
                            end else begin
                                status_next = ST_RANGE;
                            end
                        end
                        OP_DELETE: begin
                            if (!pos_lt) begin
                                status_next = ST_RANGE;
                            end else if (del_more_in) begin
                                del_next   = 1'b1;
                                state_next = S_SHRD;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (!pos_le) begin
                                status_next = ST_RANGE;
                            end else if (full) begin
                                status_next = ST_FULL;
                            end else if (pos_lt) begin
                                idx_next   = count_reg;
                                state_next = S_SHRD;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                rd_res_next = rd_data_reg;
                state_next  = S_DONE;
            end
            S_SHRD: begin
                state_next = S_SHWR;
            end
            S_SHWR: begin
                // move one tail word into place
                mem_we = 1'b1;
                mem_wa = idx_w[AW-1:0];
                mem_wd = rd_data_reg;
                if (del_reg) begin
                    idx_next = idx_reg + 1'b1;
                    if (del_more) begin
                        state_next = S_SHRD;
                    end else begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end else begin
                    idx_next = idx_reg - 1'b1;
                    if (ins_more) begin
                        state_next = S_SHRD;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = pos_reg[AW-1:0];
                mem_wd     = data_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.read_data     = rd_res_reg;
                    m_payload_next.element_count = 5'(count_reg);
                    m_payload_next.status        = status_reg;
                    state_next                   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        del_reg       <= del_next;
        data_reg      <= data_next;
        rd_res_reg    <= rd_res_next;
        status_reg    <= status_next;
        m_payload_reg <= m_payload_next;
    end

    // word store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in progress");

    a_shift_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHRD || state_reg == S_SHWR) |-> idx_reg < count_reg
        || (!del_reg && idx_reg == count_reg))
        else $error("shift index outside stored elements");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == ST_FULL
        |-> m_payload.element_count == 5'(DEPTH))
        else $error("full status with free space");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && out_free |=> m_valid)
        else $error("finished result not presented");

endmodule
